// ----- rtl/ufold_pkg.sv -----
`timescale 1ns / 1ps

package ufold_pkg;

  // Lead bytes that may open a foldable two-byte sequence
  localparam logic [7:0] LEAD_C3 = 8'hC3;
  localparam logic [7:0] LEAD_C4 = 8'hC4;
  localparam logic [7:0] LEAD_C5 = 8'hC5;
  localparam logic [7:0] LEAD_C8 = 8'hC8;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_I = 8'h69;
  localparam logic [7:0] CHAR_S = 8'h73;
  localparam logic [7:0] CHAR_T = 8'h74;

  localparam logic [7:0] NO_FOLD = 8'h00;

  // Result queue depth; must leave room for two beats per accepted input
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       string_end;
  } fold_beat_t;

  function automatic logic is_lead(input logic [7:0] b);
    return (b inside {LEAD_C3, LEAD_C4, LEAD_C5, LEAD_C8});
  endfunction

  // Plain letter for a matching pair, NO_FOLD otherwise
  function automatic logic [7:0] fold_pair(input logic [7:0] lead, input logic [7:0] nxt);
    logic [7:0] res;
    res = NO_FOLD;
    case (lead)
      LEAD_C4: begin
        if (nxt inside {8'h83, 8'h82}) res = CHAR_A;
      end
      LEAD_C3: begin
        if (nxt inside {8'hA2, 8'h82}) res = CHAR_A;
        else if (nxt inside {8'hAE, 8'h8E}) res = CHAR_I;
      end
      LEAD_C8: begin
        if (nxt inside {8'h99, 8'h98}) res = CHAR_S;
        else if (nxt inside {8'h9B, 8'h9A}) res = CHAR_T;
      end
      LEAD_C5: begin
        if (nxt inside {8'h9F, 8'h9E}) res = CHAR_S;
        else if (nxt inside {8'hA3, 8'hA2}) res = CHAR_T;
      end
      default: res = NO_FOLD;
    endcase
    return res;
  endfunction

endpackage

// ----- rtl/ufold_if.sv -----
`timescale 1ns / 1ps

interface ufold_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ufold_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

// ----- rtl/ufold_queue.sv -----
`timescale 1ns / 1ps

module ufold_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              push_cnt,
  input  ufold_pkg::fold_beat_t   push_beat0,
  input  ufold_pkg::fold_beat_t   push_beat1,
  output logic                    room2,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output ufold_pkg::fold_beat_t   pop_beat
);
  import ufold_pkg::*;

  fold_beat_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [QPTR_W-1:0]   wr_ptr_p1;
  logic                pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != '0);
  assign pop_beat  = mem_r[rd_ptr_r];
  assign room2     = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push_cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage: no reset
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push_beat0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_beat1;
    end
  end

endmodule

// ----- rtl/utf8_diacritic_fold_lowercase_top.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Payload                           Handshake
// in_ch    in   in_byte[7:0], in_last             valid/ready, beat on both high
// out_ch   out  out_byte[7:0], run_end, string_end valid/ready, beat on both high
//
// One input beat per cycle sustained while the queue has room; each beat yields
// zero, one or two result beats, which go into a four-entry result queue.
// in_ch.ready is high while the queue has room for two beats, so a result stall
// back-pressures the input only once the queue holds more than two beats.
// Reset (rst_n low, synchronous) empties the queue and drops any held lead byte.

module utf8_diacritic_fold_lowercase_top (
  input  logic clk,
  input  logic rst_n,
  ufold_in_if.sink    in_ch,
  ufold_out_if.source out_ch
);
  import ufold_pkg::*;

  // Held lead byte of a possible two-byte sequence
  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;

  logic       accept;
  logic       room2;
  logic [1:0] push_cnt;
  fold_beat_t beat0, beat1;
  fold_beat_t pop_beat;

  logic [7:0] pair_fold;
  logic       fresh;
  logic       fresh_emit;
  logic [7:0] fresh_byte;

  assign in_ch.ready = room2;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pair_fold   = fold_pair(held_r, in_ch.in_byte);

  // Fresh handling of the incoming byte: lower-case A-Z, hold a lead byte
  // unless it ends the string, pass everything else.
  always_comb begin
    fresh_byte = in_ch.in_byte;
    fresh_emit = 1'b1;
    if (in_ch.in_byte >= CHAR_UPPER_A && in_ch.in_byte <= CHAR_UPPER_Z) begin
      fresh_byte = in_ch.in_byte + CASE_OFFSET;
    end else if (is_lead(in_ch.in_byte) && !in_ch.in_last) begin
      fresh_emit = 1'b0;
    end
  end

  always_comb begin
    beat0          = '0;
    beat1          = '0;
    push_cnt       = 2'd0;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    fresh          = 1'b1;
    if (accept) begin
      // Resolve the held byte first: either it folds with this byte or it
      // goes out unchanged ahead of whatever this byte produces.
      if (held_valid_r) begin
        held_valid_nxt = 1'b0;
        held_nxt       = '0;
        push_cnt       = 2'd1;
        if (pair_fold != NO_FOLD) begin
          beat0.out_byte = pair_fold;
          fresh          = 1'b0;
        end else begin
          beat0.out_byte = held_r;
        end
      end
      if (fresh) begin
        if (fresh_emit) begin
          if (push_cnt == 2'd0) begin
            beat0.out_byte = fresh_byte;
            push_cnt       = 2'd1;
          end else begin
            beat1.out_byte = fresh_byte;
            push_cnt       = 2'd2;
          end
        end else begin
          held_nxt       = in_ch.in_byte;
          held_valid_nxt = 1'b1;
        end
      end
      // Flag the last beat this input caused
      if (push_cnt == 2'd1) begin
        beat0.run_end    = 1'b1;
        beat0.string_end = in_ch.in_last;
      end else if (push_cnt == 2'd2) begin
        beat1.run_end    = 1'b1;
        beat1.string_end = in_ch.in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      held_valid_r <= 1'b0;
    end else begin
      held_r       <= held_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  ufold_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push_beat0 (beat0),
    .push_beat1 (beat1),
    .room2      (room2),
    .pop_valid  (out_ch.valid),
    .pop_ready  (out_ch.ready),
    .pop_beat   (pop_beat)
  );

  assign out_ch.out_byte   = pop_beat.out_byte;
  assign out_ch.run_end    = pop_beat.run_end;
  assign out_ch.string_end = pop_beat.string_end;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ufold_pkg::*;

  // Cycles without a beat on either channel before the run is declared hung
  localparam int unsigned STALL_LIMIT = 2000;
  // Extra cycles to watch for stray beats once nothing is expected
  localparam int unsigned DRAIN_CYCLES = 8;

  // Folds each accepted input byte into the result beats it should cause.
  // Keeps its own copy of the held lead byte and the beats still to arrive.
  class fold_checker;
    logic [7:0] lead_hold;
    bit         lead_held;
    fold_beat_t folded_q[$];

    function void clear();
      lead_hold = 8'h00;
      lead_held = 1'b0;
      folded_q.delete();
    endfunction

    // Plain letter for a lead/follower pair, NO_FOLD when the pair is not foldable
    function logic [7:0] fold_letter(logic [7:0] lead, logic [7:0] tail);
      case ({lead, tail})
        {LEAD_C4, 8'h83}, {LEAD_C4, 8'h82},
        {LEAD_C3, 8'hA2}, {LEAD_C3, 8'h82}: return CHAR_A;
        {LEAD_C3, 8'hAE}, {LEAD_C3, 8'h8E}: return CHAR_I;
        {LEAD_C8, 8'h99}, {LEAD_C8, 8'h98},
        {LEAD_C5, 8'h9F}, {LEAD_C5, 8'h9E}: return CHAR_S;
        {LEAD_C8, 8'h9B}, {LEAD_C8, 8'h9A},
        {LEAD_C5, 8'hA3}, {LEAD_C5, 8'hA2}: return CHAR_T;
        default:                            return NO_FOLD;
      endcase
    endfunction

    function bit opens_pair(logic [7:0] b);
      return b == LEAD_C3 || b == LEAD_C4 || b == LEAD_C5 || b == LEAD_C8;
    endfunction

    // Note one accepted input beat and queue the result beats it causes
    function void take_byte(logic [7:0] b, logic last);
      fold_beat_t beats[$];
      fold_beat_t one;
      logic [7:0] letter;
      bit         fresh;
      fresh = 1'b1;
      one   = '0;
      if (lead_held) begin
        letter = fold_letter(lead_hold, b);
        if (letter != NO_FOLD) begin
          one.out_byte = letter;
          fresh = 1'b0;
        end else begin
          one.out_byte = lead_hold;
        end
        beats.push_back(one);
        lead_held = 1'b0;
        lead_hold = 8'h00;
      end
      if (fresh) begin
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
          one.out_byte = b + CASE_OFFSET;
          beats.push_back(one);
        end else if (opens_pair(b) && !last) begin
          lead_hold = b;
          lead_held = 1'b1;
        end else begin
          one.out_byte = b;
          beats.push_back(one);
        end
      end
      if (beats.size() > 0) begin
        beats[beats.size() - 1].run_end    = 1'b1;
        beats[beats.size() - 1].string_end = last;
      end
      foreach (beats[i]) folded_q.push_back(beats[i]);
    endfunction

    // Compare a result beat with the oldest expected one; empty string on a match
    function string match_beat(fold_beat_t got);
      fold_beat_t want;
      string      msg;
      if (folded_q.size() == 0)
        return $sformatf("unexpected beat byte=%02h run_end=%0b string_end=%0b",
                         got.out_byte, got.run_end, got.string_end);
      want = folded_q.pop_front();
      msg  = "";
      if (got.out_byte !== want.out_byte)
        msg = {msg, $sformatf(" out_byte got %02h want %02h", got.out_byte, want.out_byte)};
      if (got.run_end !== want.run_end)
        msg = {msg, $sformatf(" run_end got %0b want %0b", got.run_end, want.run_end)};
      if (got.string_end !== want.string_end)
        msg = {msg, $sformatf(" string_end got %0b want %0b", got.string_end,
                              want.string_end)};
      return msg;
    endfunction

    function int pending();
      return folded_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ufold_in_if  in_ch ();
  ufold_out_if out_ch ();

  utf8_diacritic_fold_lowercase_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fold_checker folds = new;

  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent   = 0;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch:%s", $time, msg);
    mismatch_cnt++;
  endtask

  // Watch both channels at every edge. Check the result beat first, then
  // note the input beat: a result can never stem from the input accepted
  // at the same edge, so the order only keeps the log tidy.
  always @(posedge clk) begin
    fold_beat_t got;
    string      msg;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.out_byte   = out_ch.out_byte;
        got.run_end    = out_ch.run_end;
        got.string_end = out_ch.string_end;
        msg = folds.match_beat(got);
        if (msg != "") report_mismatch(msg);
      end
      if (in_ch.valid && in_ch.ready)
        folds.take_byte(in_ch.in_byte, in_ch.in_last);
    end
  end

  // Hang detector: count edges with no beat on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, folds.pending());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Result side back-pressure; the idle rate changes per phase
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Offer one byte, with random idle cycles first, and hold it until a beat.
  // valid stays high on return so back-to-back bytes need no extra edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] any_lead();
    case ($urandom_range(0, 3))
      0:       return LEAD_C3;
      1:       return LEAD_C4;
      2:       return LEAD_C5;
      default: return LEAD_C8;
    endcase
  endfunction

  // The fourteen foldable sequences as {lead, follower}
  function automatic logic [15:0] fold_seq(input int unsigned idx);
    case (idx)
      0:       return {LEAD_C4, 8'h83};
      1:       return {LEAD_C4, 8'h82};
      2:       return {LEAD_C3, 8'hA2};
      3:       return {LEAD_C3, 8'h82};
      4:       return {LEAD_C3, 8'hAE};
      5:       return {LEAD_C3, 8'h8E};
      6:       return {LEAD_C8, 8'h99};
      7:       return {LEAD_C8, 8'h98};
      8:       return {LEAD_C8, 8'h9B};
      9:       return {LEAD_C8, 8'h9A};
      10:      return {LEAD_C5, 8'h9F};
      11:      return {LEAD_C5, 8'h9E};
      12:      return {LEAD_C5, 8'hA3};
      default: return {LEAD_C5, 8'hA2};
    endcase
  endfunction

  // Build one string of mostly text-like content: folds, stray lead bytes,
  // lead bytes with near-miss followers, upper case and raw bytes.
  // The final byte carries in_last.
  task automatic send_string();
    logic [7:0]  str[$];
    logic [15:0] seq;
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(1, 10);
    for (int unsigned k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        seq = fold_seq($urandom_range(0, 13));
        str.push_back(seq[15:8]);
        str.push_back(seq[7:0]);
      end else if (pick < 42) begin
        str.push_back(any_lead());
        if ($urandom_range(0, 1))
          str.push_back(8'($urandom_range(8'h80, 8'hBF)));
        else
          str.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 50) begin
        str.push_back(any_lead());
      end else if (pick < 70) begin
        str.push_back(8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z)));
      end else if (pick < 85) begin
        str.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else begin
        str.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (str[i]) send_byte(str[i], i == str.size() - 1);
  endtask

  task automatic run_phase(input int unsigned n_bytes, input int unsigned in_pct,
                           input int unsigned out_pct);
    int unsigned stop_at;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at      = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) send_string();
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    out_ch.ready  = 1'b0;
    folds.clear();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: case boundaries, byte extremes and zero
    send_byte(8'h41, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h40, 1'b0);
    send_byte(8'h5B, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // Folds from every lead byte
    send_byte(LEAD_C4, 1'b0);
    send_byte(8'h83, 1'b0);
    send_byte(LEAD_C3, 1'b0);
    send_byte(8'h8E, 1'b0);
    send_byte(LEAD_C8, 1'b0);
    send_byte(8'h9A, 1'b0);
    send_byte(LEAD_C5, 1'b0);
    send_byte(8'h9E, 1'b0);
    // Held lead with a non-matching follower that is upper case
    send_byte(LEAD_C3, 1'b0);
    send_byte(8'h41, 1'b0);
    // Held lead whose follower is itself a lead, which then folds
    send_byte(LEAD_C5, 1'b0);
    send_byte(LEAD_C8, 1'b0);
    send_byte(8'h99, 1'b0);
    // Held lead flushed by a lead byte that ends the string
    send_byte(LEAD_C8, 1'b0);
    send_byte(LEAD_C4, 1'b1);
    // Lone lead byte as the whole string, then a zero byte as the whole string
    send_byte(LEAD_C3, 1'b1);
    send_byte(8'h00, 1'b1);

    // Random strings: slow receiver and slow sender in turn, then full rate
    run_phase(667, 15, 49);
    run_phase(667, 49, 15);
    run_phase(667, 0, 0);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (folds.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
